// ===== rtl/scdc_pkg.sv =====
// ----------------------------------------------------------------------------
// scdc_pkg
// Shared constants, types and helpers for the dense code decoder.
// ----------------------------------------------------------------------------
package scdc_pkg;

    localparam int MAX_CODE_BYTES = 5;
    localparam int INDEX_WIDTH    = 40;

    localparam int CODE_W   = 8;
    localparam int RADIX_W  = CODE_W + 1;
    localparam int CNT_W    = $clog2(MAX_CODE_BYTES);
    localparam int LEN_W    = 3;
    localparam int OUT_DATA_W = ((INDEX_WIDTH + LEN_W + 7) / 8) * 8;

    localparam logic [RADIX_W-1:0] RADIX_TOTAL   = RADIX_W'(256);
    localparam logic [CODE_W-1:0]  ETDC_STOPPERS = CODE_W'(128);
    localparam logic [CNT_W-1:0]   LAST_SLOT     = CNT_W'(MAX_CODE_BYTES - 1);

    typedef logic [INDEX_WIDTH-1:0] index_t;

    // status of the base table toward the datapath
    typedef struct packed {
        logic              busy;
        logic [CODE_W-1:0] stopper;
    } table_status_t;

    // continuer radix c = 256 - s
    function automatic logic [RADIX_W-1:0] radix_of(input logic [CODE_W-1:0] s);
        radix_of = RADIX_TOTAL - {1'b0, s};
    endfunction

endpackage

// ===== rtl/scdc_base_table.sv =====
// ----------------------------------------------------------------------------
// scdc_base_table
// Holds the stopper count and builds the per-length base offsets, one entry
// per cycle after reset and after each register write.
// ----------------------------------------------------------------------------
module scdc_base_table (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [scdc_pkg::CODE_W-1:0]            cfg_data,
    input  logic [scdc_pkg::CNT_W-1:0]             rd_addr,
    output logic [scdc_pkg::INDEX_WIDTH-1:0]       rd_base,
    output scdc_pkg::table_status_t                status
);
    import scdc_pkg::*;

    logic [CODE_W-1:0]   stopper_reg;
    logic                busy_reg;
    logic [CNT_W-1:0]    slot_reg;
    index_t              sum_reg;
    index_t              term_reg;
    index_t              base_mem [MAX_CODE_BYTES];

    logic [INDEX_WIDTH+RADIX_W-1:0] term_prod;

    assign term_prod = term_reg * radix_of(stopper_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stopper_reg <= ETDC_STOPPERS;
            busy_reg    <= 1'b1;
            slot_reg    <= '0;
            sum_reg     <= '0;
            term_reg    <= INDEX_WIDTH'(ETDC_STOPPERS);
        end
        else if (cfg_valid && cfg_ready)
        begin
            stopper_reg <= cfg_data;
            busy_reg    <= 1'b1;
            slot_reg    <= '0;
            sum_reg     <= '0;
            term_reg    <= INDEX_WIDTH'(cfg_data);
        end
        else if (busy_reg)
        begin
            // base[k] = sum of s*c^j for j < k
            sum_reg  <= sum_reg + term_reg;
            term_reg <= term_prod[INDEX_WIDTH-1:0];
            if (slot_reg == LAST_SLOT)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                slot_reg <= slot_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            base_mem[slot_reg] <= sum_reg;
        end
    end

    assign rd_base        = base_mem[rd_addr];
    assign cfg_ready      = !busy_reg;
    assign status.busy    = busy_reg;
    assign status.stopper = stopper_reg;

endmodule

// ===== rtl/scdc_fold.sv =====
// ----------------------------------------------------------------------------
// scdc_fold
// Input register, codeword fold with base add, and result register.
// ----------------------------------------------------------------------------
module scdc_fold (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [scdc_pkg::CODE_W-1:0]          in_byte,
    input  scdc_pkg::table_status_t              status,
    output logic [scdc_pkg::CNT_W-1:0]           base_addr,
    input  logic [scdc_pkg::INDEX_WIDTH-1:0]     base_val,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [scdc_pkg::INDEX_WIDTH-1:0]     out_index,
    output logic [scdc_pkg::LEN_W-1:0]           out_len,
    output logic                                 out_err
);
    import scdc_pkg::*;

    logic                in_valid_reg;
    logic [CODE_W-1:0]   in_byte_reg;
    index_t              acc_reg;
    index_t              acc_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    index_t              out_index_reg;
    index_t              out_index_next;
    logic [LEN_W-1:0]    out_len_reg;
    logic [LEN_W-1:0]    out_len_next;
    logic                out_err_reg;
    logic                out_err_next;

    logic                          advance;
    logic                          is_stop;
    logic [RADIX_W-1:0]            mult_op;
    logic [CODE_W-1:0]             addend;
    logic [INDEX_WIDTH+RADIX_W-1:0] prod_full;
    index_t                        folded;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !status.busy && (!in_valid_reg || advance);

    assign is_stop   = in_byte_reg < status.stopper;
    assign mult_op   = is_stop ? {1'b0, status.stopper} : radix_of(status.stopper);
    assign addend    = is_stop ? in_byte_reg : in_byte_reg - status.stopper;
    assign prod_full = acc_reg * mult_op;
    assign folded    = prod_full[INDEX_WIDTH-1:0] + INDEX_WIDTH'(addend);
    assign base_addr = cnt_reg;

    always_comb
    begin
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_index_next = out_index_reg;
        out_len_next   = out_len_reg;
        out_err_next   = out_err_reg;
        if (advance)
        begin
            if (is_stop)
            begin
                acc_next       = '0;
                cnt_next       = '0;
                out_valid_next = 1'b1;
                out_index_next = folded + base_val;
                out_len_next   = LEN_W'(cnt_reg) + LEN_W'(1);
                out_err_next   = 1'b0;
            end
            else if (cnt_reg == LAST_SLOT)
            begin
                // overlong codeword, restart with the next byte
                acc_next       = '0;
                cnt_next       = '0;
                out_valid_next = 1'b1;
                out_index_next = '0;
                out_len_next   = '0;
                out_err_next   = 1'b1;
            end
            else
            begin
                acc_next = folded;
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= in_byte;
        end
        out_index_reg <= out_index_next;
        out_len_reg   <= out_len_next;
        out_err_reg   <= out_err_next;
    end

    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign out_len   = out_len_reg;
    assign out_err   = out_err_reg;

    a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_err_reg |-> out_len_reg == '0 && out_index_reg == '0)
        else $error("error result carries nonzero fields");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= LAST_SLOT)
        else $error("byte count beyond last slot");

    a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && is_stop |=> cnt_reg == '0 && acc_reg == '0 && out_valid_reg)
        else $error("stopper did not close the codeword");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        status.busy |-> !in_ready)
        else $error("byte taken while base table builds");

endmodule

// ===== rtl/scdc_codeword_decoder.sv =====
// ----------------------------------------------------------------------------
// scdc_codeword_decoder
// (s,c)-dense code decoder: code bytes in, vocabulary word indices out.
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  s_*      | in  | tdata[7:0] code_byte
//  m_*      | out | tdata[39:0] word_index, [42:40] code_length; tuser error
//  cfg_*    | in  | cfg_data[7:0] stopper_count
//
//  one code byte per cycle sustained while the base table is idle and m_tready
//  does not stall; m_tvalid rises once the stopper byte has passed the input
//  register and the fold has written the result register; the fold is one 40x9
//  multiply-add plus the base add per cycle; after reset and after each cfg
//  transaction the base table rebuilds, with s_tready and cfg_ready low
//  a stalled m_tready holds the result; one more byte waits in the input register
// ----------------------------------------------------------------------------
module scdc_codeword_decoder (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [scdc_pkg::CODE_W-1:0]         s_tdata,   // code_byte
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [scdc_pkg::OUT_DATA_W-1:0]     m_tdata,   // word_index, code_length
    output logic                                m_tuser,   // error
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [scdc_pkg::CODE_W-1:0]         cfg_data   // stopper_count
);
    import scdc_pkg::*;

    table_status_t       status;
    logic [CNT_W-1:0]    base_addr;
    index_t              base_val;
    index_t              out_index;
    logic [LEN_W-1:0]    out_len;

    scdc_base_table u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .rd_addr   (base_addr),
        .rd_base   (base_val),
        .status    (status)
    );

    scdc_fold u_fold (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .status    (status),
        .base_addr (base_addr),
        .base_val  (base_val),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_index (out_index),
        .out_len   (out_len),
        .out_err   (m_tuser)
    );

    assign m_tdata = OUT_DATA_W'({out_len, out_index});

endmodule
